// File: src/lpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_pkg: shared types, constants and table functions
// widths of the register and word fields, register indexes, stage enables
// and the exact integer sine table builder evaluated at elaboration
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int RADIUS_W  = 15;
  localparam int ANGLE_W   = 32;
  localparam int COUNT_W   = 17;
  localparam int INDEX_W   = 16;
  localparam int COORD_W   = 16;
  localparam int SAMPLE_W  = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ANGLE_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ANGLE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_PHASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 3'd4;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd16384;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 17'd1000;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // pi in q62
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;

  // load enables of the pipeline stages behind the input register
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // (a*b) >> sh, optionally rounded half up
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh, input logic rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (rnd) begin
      p = p + (128'd1 << (sh - 1));
    end
    return 64'(p >> sh);
  endfunction

  // floor(n / d), shift and subtract, only run while the table is built
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(x) for 0 <= x <= pi/2, q62 in and out, taylor series
  function automatic logic [63:0] sin_q62(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    x2   = mul_shift(x, x, 62, 1'b0);
    term = x;
    sum  = x;
    for (int i = 1; i <= 13; i++) begin
      den  = 64'((2 * i) * (2 * i + 1));
      term = div_u64(mul_shift(term, x2, 62, 1'b0), den);
      if (i[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // quarter-wave entry k: round(32767*sin(2*pi*(k+0.5)/2^(qtb+2)))
  function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
                                                     input int unsigned qtb);
    logic [63:0] theta;
    logic [63:0] val;
    theta = mul_shift(PI_Q62, 64'(2 * k + 1), qtb + 2, 1'b0);
    val   = mul_shift(sin_q62(theta), 64'd32767, 62, 1'b1);
    return val[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/lpg_angle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_angle: angle multiply and table address stages
// stage 2 multiplies the index by both steps, stage 3 adds the phase and
// folds the angle into a quarter-wave address and a sign
// ----------------------------------------------------------------------------
module lpg_angle
  import lpg_pkg::*;
#(
  parameter int IDX_W              = 16,
  parameter int QUARTER_TABLE_BITS = 10
) (
  input  wire                          clk,
  input  stage_en_t                    stage_en,
  input  wire [IDX_W-1:0]              idx,
  input  wire [ANGLE_W-1:0]            x_angle_step,
  input  wire [ANGLE_W-1:0]            y_angle_step,
  input  wire [ANGLE_W-1:0]            x_phase,
  output logic [QUARTER_TABLE_BITS-1:0] x_addr,
  output logic                          x_neg,
  output logic [QUARTER_TABLE_BITS-1:0] y_addr,
  output logic                          y_neg
);

  localparam int PW = QUARTER_TABLE_BITS + 2;

  logic [IDX_W+ANGLE_W-1:0] x_full;
  logic [IDX_W+ANGLE_W-1:0] y_full;
  logic [ANGLE_W-1:0]       x_prod_r;
  logic [ANGLE_W-1:0]       y_prod_r;
  logic [ANGLE_W-1:0]       x_angle;
  logic [PW-1:0]            x_p;
  logic [PW-1:0]            y_p;
  logic [QUARTER_TABLE_BITS-1:0] x_addr_nxt;
  logic [QUARTER_TABLE_BITS-1:0] y_addr_nxt;
  logic [QUARTER_TABLE_BITS-1:0] x_addr_r;
  logic [QUARTER_TABLE_BITS-1:0] y_addr_r;
  logic                          x_neg_r;
  logic                          y_neg_r;

  assign x_full = {{ANGLE_W{1'b0}}, idx} * {{IDX_W{1'b0}}, x_angle_step};
  assign y_full = {{ANGLE_W{1'b0}}, idx} * {{IDX_W{1'b0}}, y_angle_step};

  always_ff @(posedge clk) begin
    if (stage_en.s2) begin
      x_prod_r <= x_full[ANGLE_W-1:0];
      y_prod_r <= y_full[ANGLE_W-1:0];
    end
  end

  // cosine is the sine a quarter turn on
  assign x_angle = x_prod_r + x_phase + QUARTER_TURN;
  assign x_p     = x_angle[ANGLE_W-1 -: PW];
  assign y_p     = y_prod_r[ANGLE_W-1 -: PW];

  // odd quadrants read the table mirrored
  assign x_addr_nxt = x_p[QUARTER_TABLE_BITS] ? ~x_p[QUARTER_TABLE_BITS-1:0]
                                              : x_p[QUARTER_TABLE_BITS-1:0];
  assign y_addr_nxt = y_p[QUARTER_TABLE_BITS] ? ~y_p[QUARTER_TABLE_BITS-1:0]
                                              : y_p[QUARTER_TABLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (stage_en.s3) begin
      x_addr_r <= x_addr_nxt;
      y_addr_r <= y_addr_nxt;
      x_neg_r  <= x_p[PW-1];
      y_neg_r  <= y_p[PW-1];
    end
  end

  assign x_addr = x_addr_r;
  assign y_addr = y_addr_r;
  assign x_neg  = x_neg_r;
  assign y_neg  = y_neg_r;

endmodule
`default_nettype wire

// File: src/lpg_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_sine_rom: quarter-wave sine table, two registered read ports
// contents are built at elaboration; signs travel alongside the data
// ----------------------------------------------------------------------------
module lpg_sine_rom
  import lpg_pkg::*;
#(
  parameter int QUARTER_TABLE_BITS = 10
) (
  input  wire                           clk,
  input  stage_en_t                     stage_en,
  input  wire [QUARTER_TABLE_BITS-1:0]  x_addr,
  input  wire                           x_neg,
  input  wire [QUARTER_TABLE_BITS-1:0]  y_addr,
  input  wire                           y_neg,
  output logic [SAMPLE_W-1:0]           x_mag,
  output logic                          x_neg_out,
  output logic [SAMPLE_W-1:0]           y_mag,
  output logic                          y_neg_out
);

  localparam int QSIZE = 1 << QUARTER_TABLE_BITS;

  typedef logic [SAMPLE_W-1:0] rom_t [QSIZE];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < QSIZE; k++) begin
      t[k] = sine_entry(k, QUARTER_TABLE_BITS);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [SAMPLE_W-1:0] x_mag_r;
  logic [SAMPLE_W-1:0] y_mag_r;
  logic                x_neg_r;
  logic                y_neg_r;

  always_ff @(posedge clk) begin
    if (stage_en.s4) begin
      x_mag_r <= SINE_ROM[x_addr];
      y_mag_r <= SINE_ROM[y_addr];
      x_neg_r <= x_neg;
      y_neg_r <= y_neg;
    end
  end

  assign x_mag     = x_mag_r;
  assign y_mag     = y_mag_r;
  assign x_neg_out = x_neg_r;
  assign y_neg_out = y_neg_r;

endmodule
`default_nettype wire

// File: src/lpg_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_scale: radius scaling and output coordinate register
// applies the sign, multiplies by the radius, floor shift by 15
// ----------------------------------------------------------------------------
module lpg_scale
  import lpg_pkg::*;
(
  input  wire                        clk,
  input  stage_en_t                  stage_en,
  input  wire [RADIUS_W-1:0]         radius,
  input  wire [SAMPLE_W-1:0]         x_mag,
  input  wire                        x_neg,
  input  wire [SAMPLE_W-1:0]         y_mag,
  input  wire                        y_neg,
  output logic signed [COORD_W-1:0]  x_coord,
  output logic signed [COORD_W-1:0]  y_coord
);

  localparam int PROD_W = 2 * COORD_W;

  logic signed [COORD_W-1:0] x_val;
  logic signed [COORD_W-1:0] y_val;
  logic signed [COORD_W-1:0] rad_s;
  logic signed [PROD_W-1:0]  x_prod_nxt;
  logic signed [PROD_W-1:0]  y_prod_nxt;
  logic signed [PROD_W-1:0]  x_prod_r;
  logic signed [PROD_W-1:0]  y_prod_r;

  assign rad_s = signed'({1'b0, radius});
  assign x_val = x_neg ? -signed'({1'b0, x_mag}) : signed'({1'b0, x_mag});
  assign y_val = y_neg ? -signed'({1'b0, y_mag}) : signed'({1'b0, y_mag});

  assign x_prod_nxt = rad_s * x_val;
  assign y_prod_nxt = rad_s * y_val;

  always_ff @(posedge clk) begin
    if (stage_en.s5) begin
      x_prod_r <= x_prod_nxt;
      y_prod_r <= y_prod_nxt;
    end
  end

  // |product| < 2^30, so bits 30:15 are the floor-shifted value
  assign x_coord = x_prod_r[COORD_W+SAMPLE_W-1:SAMPLE_W];
  assign y_coord = y_prod_r[COORD_W+SAMPLE_W-1:SAMPLE_W];

endmodule
`default_nettype wire

// File: src/lissajous_point_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lissajous_point_generator_core: lissajous curve point generator
// one point index in, one (x, y, last) point word out
// ----------------------------------------------------------------------------
// For each point index word the core returns x = radius*cos(x_phase +
// index*x_angle_step) and y = radius*sin(index*y_angle_step), angles being
// 32-bit fractions of a turn, plus a last_point flag when the index equals
// point_count-1. It takes one word per clock, unless out_stall holds a full
// pipeline, through five register stages: input register, the two 16x32
// angle multipliers, phase add and table fold, the registered quarter-wave
// table read, and the radius multiplier which is also the output register.
// Every stage holds only while the one after it is full and held, so bubbles
// close up and an output waiting on out_stall stops new words from entering
// only once every stage is full. Registers are plain writes and must only
// change while the core is empty.
// ----------------------------------------------------------------------------
module lissajous_point_generator_core
  import lpg_pkg::*;
#(
  parameter int INDEX_BITS         = 16,
  parameter int QUARTER_TABLE_BITS = 10
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // configuration write port
  input  wire                        cfg_we,
  input  wire [CFG_IDX_W-1:0]        cfg_index,
  input  wire [CFG_DATA_W-1:0]       cfg_wdata,
  // input words
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [INDEX_W-1:0]          in_point_index,
  // output words
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [COORD_W-1:0]  out_x_coord,
  output logic signed [COORD_W-1:0]  out_y_coord,
  output logic                       out_last_point
);

  // only the low index bits take part
  localparam int IDX_W = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  localparam int NSTG  = 5;

  // configuration registers
  logic [RADIUS_W-1:0] radius_r;
  logic [ANGLE_W-1:0]  x_angle_step_r;
  logic [ANGLE_W-1:0]  y_angle_step_r;
  logic [ANGLE_W-1:0]  x_phase_r;
  logic [COUNT_W-1:0]  point_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r       <= RADIUS_RST;
      x_angle_step_r <= '0;
      y_angle_step_r <= '0;
      x_phase_r      <= '0;
      point_count_r  <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS:       radius_r       <= cfg_wdata[RADIUS_W-1:0];
        CFG_X_ANGLE_STEP: x_angle_step_r <= cfg_wdata[ANGLE_W-1:0];
        CFG_Y_ANGLE_STEP: y_angle_step_r <= cfg_wdata[ANGLE_W-1:0];
        CFG_X_PHASE:      x_phase_r      <= cfg_wdata[ANGLE_W-1:0];
        CFG_POINT_COUNT:  point_count_r  <= cfg_wdata[COUNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pipeline control: valid per stage, load when empty or draining
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] last_r;
  logic [NSTG-1:0] load;
  stage_en_t       stage_en;

  always_comb begin
    load[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      load[i] = !vld_r[i] || load[i+1];
    end
  end

  assign stage_en.s2 = load[1];
  assign stage_en.s3 = load[2];
  assign stage_en.s4 = load[3];
  assign stage_en.s5 = load[4];

  assign in_stall = !load[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (load[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (load[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // stage 1: index register and last-point compare
  logic [IDX_W-1:0]   idx_r;
  logic [COUNT_W-1:0] count_m1;
  logic               last_nxt;

  assign count_m1 = point_count_r - COUNT_W'(1);
  assign last_nxt = (point_count_r != '0) &&
                    (COUNT_W'(in_point_index[IDX_W-1:0]) == count_m1);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      idx_r     <= in_point_index[IDX_W-1:0];
      last_r[0] <= last_nxt;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (load[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  // stages 2 and 3: angles and table addresses
  logic [QUARTER_TABLE_BITS-1:0] x_addr;
  logic [QUARTER_TABLE_BITS-1:0] y_addr;
  logic                          x_neg_a;
  logic                          y_neg_a;

  lpg_angle #(
    .IDX_W              (IDX_W),
    .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
  ) u_angle (
    .clk          (clk),
    .stage_en     (stage_en),
    .idx          (idx_r),
    .x_angle_step (x_angle_step_r),
    .y_angle_step (y_angle_step_r),
    .x_phase      (x_phase_r),
    .x_addr       (x_addr),
    .x_neg        (x_neg_a),
    .y_addr       (y_addr),
    .y_neg        (y_neg_a)
  );

  // stage 4: quarter-wave table read
  logic [SAMPLE_W-1:0] x_mag;
  logic [SAMPLE_W-1:0] y_mag;
  logic                x_neg_t;
  logic                y_neg_t;

  lpg_sine_rom #(
    .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
  ) u_rom (
    .clk       (clk),
    .stage_en  (stage_en),
    .x_addr    (x_addr),
    .x_neg     (x_neg_a),
    .y_addr    (y_addr),
    .y_neg     (y_neg_a),
    .x_mag     (x_mag),
    .x_neg_out (x_neg_t),
    .y_mag     (y_mag),
    .y_neg_out (y_neg_t)
  );

  // stage 5: radius scaling, doubles as the output register
  lpg_scale u_scale (
    .clk      (clk),
    .stage_en (stage_en),
    .radius   (radius_r),
    .x_mag    (x_mag),
    .x_neg    (x_neg_t),
    .y_mag    (y_mag),
    .y_neg    (y_neg_t),
    .x_coord  (out_x_coord),
    .y_coord  (out_y_coord)
  );

  assign out_valid      = vld_r[NSTG-1];
  assign out_last_point = last_r[NSTG-1];

endmodule
`default_nettype wire
